>>> src/pgb_pkg.sv
// Shared types, codes and constants of the proportional glyph row blitter.
package pgb_pkg;

	localparam int DISPLAY_WIDTH      = 128;
	localparam int MAX_GLYPH_WIDTH    = 16;
	localparam int BITMAP_BYTES_DEF   = 4096;
	localparam int GLYPH_COUNT_DEF    = 256;

	localparam int MASK_W   = 16;
	localparam int GWIDTH_W = 5;
	localparam int OFFSET_W = 12;
	localparam int ROW_W    = 5;
	localparam int BPR_W    = 3;

	localparam logic [1:0] CMD_LOAD_GLYPH = 2'd0;
	localparam logic [1:0] CMD_LOAD_BYTE  = 2'd1;
	localparam logic [1:0] CMD_DRAW       = 2'd2;

	localparam logic [2:0] REG_CLIP_LEFT   = 3'd0;
	localparam logic [2:0] REG_CLIP_RIGHT  = 3'd1;
	localparam logic [2:0] REG_TRACKING    = 3'd2;
	localparam logic [2:0] REG_FONT_HEIGHT = 3'd3;
	localparam logic [2:0] REG_DRAW_VALUE  = 3'd4;

	localparam logic signed [11:0] CLIP_LEFT_RST   = 12'sd0;
	localparam logic signed [11:0] CLIP_RIGHT_RST  = 12'sd128;
	localparam logic signed [4:0]  TRACKING_RST    = 5'sd1;
	localparam logic [5:0]         FONT_HEIGHT_RST = 6'd8;
	localparam logic               DRAW_VALUE_RST  = 1'b1;

	typedef struct packed {
		logic [GWIDTH_W-1:0] width;
		logic [OFFSET_W-1:0] offset;
	} glyph_entry_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LOAD1,
		ST_LOAD2,
		ST_GLYPH,
		ST_ADDR1,
		ST_ADDR2,
		ST_ROWS,
		ST_EMPTY
	} state_t;

endpackage

>>> src/pgb_addr_mod.sv
// Two-stage reduction of a 12-bit byte address modulo the bitmap size.
module pgb_addr_mod #(
	parameter int BITMAP_BYTES = pgb_pkg::BITMAP_BYTES_DEF
) (
	input  logic                            clk,
	input  logic [11:0]                     value,
	output logic [$clog2(BITMAP_BYTES)-1:0] result
);
	import pgb_pkg::*;

	localparam int AW = $clog2(BITMAP_BYTES);
	localparam int SH = 24;
	localparam logic [16:0] RECIP = 17'((32'd1 << SH) / BITMAP_BYTES);

	logic [28:0] prod;
	logic [11:0] value_s1;
	logic [4:0]  quot_s1;
	logic [22:0] rem_raw;
	logic [22:0] rem_fix;
	logic [AW-1:0] result_s2;

	assign prod = 29'(value) * 29'(RECIP);

	always_ff @(posedge clk) begin
		value_s1 <= value;
		quot_s1  <= prod[28:24];
	end

	always_comb begin
		rem_raw = 23'(value_s1) - 23'(quot_s1) * 23'(BITMAP_BYTES);
		rem_fix = (rem_raw >= 23'(BITMAP_BYTES)) ? rem_raw - 23'(BITMAP_BYTES) : rem_raw;
	end

	always_ff @(posedge clk) begin
		result_s2 <= rem_fix[AW-1:0];
	end

	assign result = result_s2;

endmodule

>>> src/pgb_glyph_store.sv
// Glyph entry table: width and bitmap start offset per character.
module pgb_glyph_store #(
	parameter int GLYPH_COUNT = pgb_pkg::GLYPH_COUNT_DEF
) (
	input  logic                           clk,
	input  logic                           wr_en,
	input  logic                           rd_en,
	input  logic [$clog2(GLYPH_COUNT)-1:0] addr,
	input  pgb_pkg::glyph_entry_t          wr_data,
	output pgb_pkg::glyph_entry_t          rd_data
);
	import pgb_pkg::*;

	glyph_entry_t mem [GLYPH_COUNT];
	glyph_entry_t rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem[addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

>>> src/pgb_bitmap_store.sv
// Glyph bitmap byte memory: one write port, two registered read ports.
module pgb_bitmap_store #(
	parameter int BITMAP_BYTES = pgb_pkg::BITMAP_BYTES_DEF
) (
	input  logic                            clk,
	input  logic                            wr_en,
	input  logic [$clog2(BITMAP_BYTES)-1:0] wr_addr,
	input  logic [7:0]                      wr_data,
	input  logic                            rd_en,
	input  logic [$clog2(BITMAP_BYTES)-1:0] rd_addr0,
	input  logic [$clog2(BITMAP_BYTES)-1:0] rd_addr1,
	output logic [7:0]                      rd_data0,
	output logic [7:0]                      rd_data1
);
	import pgb_pkg::*;

	logic [7:0] mem [BITMAP_BYTES];
	logic [7:0] rd_data0_q;
	logic [7:0] rd_data1_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data0_q <= mem[rd_addr0];
			rd_data1_q <= mem[rd_addr1];
		end
	end

	assign rd_data0 = rd_data0_q;
	assign rd_data1 = rd_data1_q;

endmodule

>>> src/proportional_glyph_row_blitter_top.sv
// Top level of the proportional glyph row blitter: control, pen state and output register.
//
//  channel | direction | handshake             | payload
//  --------+-----------+-----------------------+---------------------------------------------
//  in      | in        | in_valid / in_ready   | command char_code first_of_text start_x
//          |           |                       | start_y glyph_width bitmap_address bitmap_byte
//  out     | out       | out_valid / out_ready | row_y span_x pixel_mask pixel_value
//          |           |                       | text_advance last
//  cfg     | in        | cfg_valid / cfg_ready | cfg_index cfg_data
//
// Load glyph entry: written from the input word in the idle state. Load bitmap byte: written
// after the two-stage address reduction. Draw: the table read and the two-stage reduction of
// the glyph offset, then one glyph row a cycle from the dual-read bitmap memory while the output
// register can take it. A glyph left of the window gives one empty span; a draw that stops ends.
// Reset restores the register defaults and clears the pen; the glyph table and the bitmap
// memory hold nothing valid until loaded. A row waits while the output register is full.
module proportional_glyph_row_blitter_top #(
	parameter int BITMAP_BYTES = pgb_pkg::BITMAP_BYTES_DEF,
	parameter int GLYPH_COUNT  = pgb_pkg::GLYPH_COUNT_DEF
) (
	input  logic               clk,
	input  logic               arst_n,

	input  logic               in_valid,
	output logic               in_ready,
	input  logic [1:0]         command,
	input  logic [7:0]         char_code,
	input  logic               first_of_text,
	input  logic signed [11:0] start_x,
	input  logic signed [11:0] start_y,
	input  logic [4:0]         glyph_width,
	input  logic [11:0]        bitmap_address,
	input  logic [7:0]         bitmap_byte,

	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [12:0] row_y,
	output logic signed [12:0] span_x,
	output logic [15:0]        pixel_mask,
	output logic               pixel_value,
	output logic [12:0]        text_advance,
	output logic               last,

	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [2:0]         cfg_index,
	input  logic [11:0]        cfg_data
);
	import pgb_pkg::*;

	localparam int AW  = $clog2(BITMAP_BYTES);
	localparam int GAW = $clog2(GLYPH_COUNT);
	localparam logic [AW:0] BB  = (AW+1)'(BITMAP_BYTES);
	localparam logic [8:0]  GC9 = 9'(GLYPH_COUNT);
	localparam logic signed [13:0] PEN_MIN14 = -14'sd4096;
	localparam logic signed [13:0] PEN_MAX14 = 14'sd4095;
	localparam logic signed [13:0] DW14      = 14'(DISPLAY_WIDTH);

	state_t state_q, state_d;

	logic signed [11:0] clip_left_q, clip_right_q;
	logic signed [4:0]  tracking_q;
	logic [5:0]         font_height_q;
	logic               draw_value_q;

	logic signed [12:0] pen_x_q;
	logic signed [11:0] origin_x_q, pen_y_q;
	logic               stopped_q;

	logic [7:0]          byte_q;
	logic signed [12:0]  x0_q;
	logic [12:0]         adv_q;
	logic [BPR_W-1:0]    bpr_q;
	logic [MASK_W-1:0]   colmask_q;
	logic [ROW_W-1:0]    row_q;
	logic [AW-1:0]       row_base_q;

	logic               out_valid_q;
	logic signed [12:0] row_y_q, span_x_q;
	logic [15:0]        mask_q;
	logic               value_q;
	logic [12:0]        adv_out_q;
	logic               last_q;

	logic               in_fire, out_free, out_load, do_stop, is_left, row_last;
	logic               tbl_we, tbl_re, bm_we, bm_re;
	logic [GAW-1:0]     glyph_idx;
	glyph_entry_t       tbl_wdata, tbl_rdata;
	logic [11:0]        mod_value;
	logic [AW-1:0]      mod_result;
	logic [AW-1:0]      next_base, base_sel, rd_addr1;
	logic [AW:0]        base_sum, addr1_sum;
	logic [7:0]         rd_data0, rd_data1;
	logic [ROW_W-1:0]   hm1;
	logic signed [13:0] pen14, w14, trk14, sum14, cl14, cr14;
	logic signed [12:0] pen_new;
	logic [MASK_W-1:0]  colmask_d, row_mask;
	logic [15:0]        row_bits;

	assign cfg_ready = 1'b1;
	assign in_fire   = in_valid && in_ready;
	assign out_free  = !out_valid_q || out_ready;

	always_comb begin
		if ({1'b0, char_code} >= GC9) begin
			glyph_idx = GAW'({1'b0, char_code} - GC9);
		end else begin
			glyph_idx = GAW'(char_code);
		end
		tbl_wdata.offset = bitmap_address;
		if (int'(glyph_width) > MAX_GLYPH_WIDTH) begin
			tbl_wdata.width = GWIDTH_W'(MAX_GLYPH_WIDTH);
		end else begin
			tbl_wdata.width = glyph_width;
		end
	end

	always_comb begin
		if (font_height_q == 6'd0) begin
			hm1 = '0;
		end else if (font_height_q > 6'd32) begin
			hm1 = ROW_W'(31);
		end else begin
			hm1 = ROW_W'(font_height_q - 6'd1);
		end
	end

	assign row_last = (row_q == hm1);

	// pen arithmetic on the glyph entry just read
	always_comb begin
		logic signed [13:0] px;
		pen14 = {pen_x_q[12], pen_x_q};
		w14   = {9'b0, tbl_rdata.width};
		trk14 = {{9{tracking_q[4]}}, tracking_q};
		cl14  = {{2{clip_left_q[11]}}, clip_left_q};
		cr14  = {{2{clip_right_q[11]}}, clip_right_q};
		sum14 = pen14 + w14 + trk14;
		if (sum14 < PEN_MIN14) begin
			pen_new = PEN_MIN14[12:0];
		end else if (sum14 > PEN_MAX14) begin
			pen_new = PEN_MAX14[12:0];
		end else begin
			pen_new = sum14[12:0];
		end
		do_stop = stopped_q || (pen14 >= cr14) || (pen14 >= DW14);
		is_left = (pen14 + w14) <= cl14;
		for (int c = 0; c < MASK_W; c++) begin
			px = pen14 + $signed({9'b0, 5'(c)});
			colmask_d[c] = (5'(c) < tbl_rdata.width) && (px >= cl14) && (px < cr14);
		end
	end

	assign mod_value = (state_q == ST_GLYPH) ? tbl_rdata.offset : bitmap_address;

	always_comb begin
		base_sum = {1'b0, row_base_q} + (AW+1)'(bpr_q);
		if (base_sum >= BB) begin
			next_base = AW'(base_sum - BB);
		end else begin
			next_base = base_sum[AW-1:0];
		end
		base_sel  = (state_q == ST_ADDR2) ? mod_result : next_base;
		addr1_sum = {1'b0, base_sel} + (AW+1)'(1);
		if (addr1_sum == BB) begin
			rd_addr1 = '0;
		end else begin
			rd_addr1 = addr1_sum[AW-1:0];
		end
	end

	always_comb begin
		row_bits = {rd_data0, rd_data1};
		for (int c = 0; c < MASK_W; c++) begin
			row_mask[c] = colmask_q[c] & row_bits[MASK_W-1-c];
		end
	end

	always_comb begin
		state_d  = state_q;
		in_ready = 1'b0;
		tbl_we   = 1'b0;
		tbl_re   = 1'b0;
		bm_we    = 1'b0;
		bm_re    = 1'b0;
		out_load = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					case (command)
						CMD_LOAD_GLYPH: tbl_we = 1'b1;
						CMD_LOAD_BYTE:  state_d = ST_LOAD1;
						CMD_DRAW: begin
							tbl_re  = 1'b1;
							state_d = ST_GLYPH;
						end
						default: state_d = ST_IDLE;
					endcase
				end
			end
			ST_LOAD1: state_d = ST_LOAD2;
			ST_LOAD2: begin
				bm_we   = 1'b1;
				state_d = ST_IDLE;
			end
			ST_GLYPH: begin
				if (do_stop) begin
					state_d = ST_IDLE;
				end else if (is_left) begin
					state_d = ST_EMPTY;
				end else begin
					state_d = ST_ADDR1;
				end
			end
			ST_ADDR1: state_d = ST_ADDR2;
			ST_ADDR2: begin
				bm_re   = 1'b1;
				state_d = ST_ROWS;
			end
			ST_ROWS: begin
				if (out_free) begin
					out_load = 1'b1;
					if (row_last) begin
						state_d = ST_IDLE;
					end else begin
						bm_re = 1'b1;
					end
				end
			end
			ST_EMPTY: begin
				if (out_free) begin
					out_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clip_left_q   <= CLIP_LEFT_RST;
			clip_right_q  <= CLIP_RIGHT_RST;
			tracking_q    <= TRACKING_RST;
			font_height_q <= FONT_HEIGHT_RST;
			draw_value_q  <= DRAW_VALUE_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_CLIP_LEFT:   clip_left_q   <= cfg_data;
				REG_CLIP_RIGHT:  clip_right_q  <= cfg_data;
				REG_TRACKING:    tracking_q    <= cfg_data[4:0];
				REG_FONT_HEIGHT: font_height_q <= cfg_data[5:0];
				REG_DRAW_VALUE:  draw_value_q  <= cfg_data[0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pen_x_q    <= '0;
			origin_x_q <= '0;
			pen_y_q    <= '0;
			stopped_q  <= 1'b0;
		end else if (in_fire && command == CMD_DRAW && first_of_text) begin
			pen_x_q    <= {start_x[11], start_x};
			origin_x_q <= start_x;
			pen_y_q    <= start_y;
			stopped_q  <= 1'b0;
		end else if (state_q == ST_GLYPH) begin
			if (do_stop) begin
				stopped_q <= 1'b1;
			end else begin
				pen_x_q <= pen_new;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			byte_q <= bitmap_byte;
		end
		if (state_q == ST_GLYPH) begin
			x0_q      <= pen_x_q;
			adv_q     <= 13'(pen_new - {origin_x_q[11], origin_x_q});
			bpr_q     <= BPR_W'((tbl_rdata.width + 5'd7) >> 3);
			colmask_q <= colmask_d;
			row_q     <= '0;
		end
		if (state_q == ST_ADDR2) begin
			row_base_q <= mod_result;
		end else if (state_q == ST_ROWS && out_free && !row_last) begin
			row_base_q <= next_base;
			row_q      <= row_q + ROW_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			span_x_q  <= x0_q;
			value_q   <= draw_value_q;
			adv_out_q <= adv_q;
			if (state_q == ST_ROWS) begin
				row_y_q <= {pen_y_q[11], pen_y_q} + 13'(row_q);
				mask_q  <= row_mask;
				last_q  <= row_last;
			end else begin
				row_y_q <= {pen_y_q[11], pen_y_q};
				mask_q  <= '0;
				last_q  <= 1'b1;
			end
		end
	end

	assign out_valid    = out_valid_q;
	assign row_y        = row_y_q;
	assign span_x       = span_x_q;
	assign pixel_mask   = mask_q;
	assign pixel_value  = value_q;
	assign text_advance = adv_out_q;
	assign last         = last_q;

	pgb_glyph_store #(
		.GLYPH_COUNT(GLYPH_COUNT)
	) u_glyph_store (
		.clk    (clk),
		.wr_en  (tbl_we),
		.rd_en  (tbl_re),
		.addr   (glyph_idx),
		.wr_data(tbl_wdata),
		.rd_data(tbl_rdata)
	);

	pgb_addr_mod #(
		.BITMAP_BYTES(BITMAP_BYTES)
	) u_addr_mod (
		.clk   (clk),
		.value (mod_value),
		.result(mod_result)
	);

	pgb_bitmap_store #(
		.BITMAP_BYTES(BITMAP_BYTES)
	) u_bitmap_store (
		.clk     (clk),
		.wr_en   (bm_we),
		.wr_addr (mod_result),
		.wr_data (byte_q),
		.rd_en   (bm_re),
		.rd_addr0(base_sel),
		.rd_addr1(rd_addr1),
		.rd_data0(rd_data0),
		.rd_data1(rd_data1)
	);

	a_last_row_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_ROWS && out_free && row_last) |=> state_q == ST_IDLE)
		else $error("draw did not end after its last row");

	a_row_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_ROWS) |-> (row_q <= hm1))
		else $error("row counter past font height");

	a_bitmap_port: assert property (@(posedge clk) disable iff (!arst_n)
		!(bm_we && bm_re))
		else $error("bitmap written and read in one cycle");

	a_stop_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_GLYPH && stopped_q) |=> (state_q == ST_IDLE && stopped_q && !out_load))
		else $error("stopped draw produced work");

endmodule

>>> tb/tb.sv
// Self-checking testbench for the proportional glyph row blitter: directed, pressure and random text.
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import pgb_pkg::*;

	localparam logic [1:0] CMD_UNUSED = 2'd3;
	localparam int STALL_LIMIT   = 2000;
	localparam int SETTLE_CYCLES = 40;
	localparam int PEN_MIN       = -4096;
	localparam int PEN_MAX       = 4095;

	typedef struct {
		logic [1:0]         cmd;
		logic [7:0]         code;
		logic               first;
		logic signed [11:0] sx;
		logic signed [11:0] sy;
		logic [4:0]         width;
		logic [11:0]        addr;
		logic [7:0]         data;
	} word_t;

	typedef struct {
		logic signed [12:0] row_y;
		logic signed [12:0] span_x;
		logic [15:0]        mask;
		logic               value;
		logic [12:0]        advance;
		logic               last;
	} span_t;

	logic               clk = 1'b0;
	logic               arst_n;
	logic               in_valid;
	logic               in_ready;
	logic [1:0]         command;
	logic [7:0]         char_code;
	logic               first_of_text;
	logic signed [11:0] start_x;
	logic signed [11:0] start_y;
	logic [4:0]         glyph_width;
	logic [11:0]        bitmap_address;
	logic [7:0]         bitmap_byte;
	logic               out_valid;
	logic               out_ready;
	logic signed [12:0] row_y;
	logic signed [12:0] span_x;
	logic [15:0]        pixel_mask;
	logic               pixel_value;
	logic [12:0]        text_advance;
	logic               last;
	logic               cfg_valid;
	logic               cfg_ready;
	logic [2:0]         cfg_index;
	logic [11:0]        cfg_data;

	proportional_glyph_row_blitter_top dut (.*);

	// glyph store, font memory, pen and register copies
	int    gl_width [GLYPH_COUNT_DEF];
	int    gl_offset[GLYPH_COUNT_DEF];
	bit    gl_known [GLYPH_COUNT_DEF];
	bit [7:0] font_rom [BITMAP_BYTES_DEF];
	bit    rom_known[BITMAP_BYTES_DEF];
	int    pen_x, origin_x, pen_y;
	bit    stopped;
	int    clip_l, clip_r, track, font_h;
	bit    draw_val;

	span_t spans_due[$];
	span_t due_span;
	int    errors = 0;
	int    quiet_cycles = 0;
	int    hold_left = 0;
	bit    calm = 1'b0;
	logic [7:0] pool[8] = '{8'h00, 8'h20, 8'h41, 8'h61, 8'h7E, 8'h80, 8'hC3, 8'hFF};

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	function automatic int font_rows();
		if (font_h < 1)
			return 1;
		if (font_h > 32)
			return 32;
		return font_h;
	endfunction

	function automatic void model_reset();
		foreach (gl_known[i]) gl_known[i] = 1'b0;
		foreach (rom_known[i]) rom_known[i] = 1'b0;
		pen_x = 0;
		origin_x = 0;
		pen_y = 0;
		stopped = 1'b0;
		clip_l = CLIP_LEFT_RST;
		clip_r = CLIP_RIGHT_RST;
		track = TRACKING_RST;
		font_h = FONT_HEIGHT_RST;
		draw_val = DRAW_VALUE_RST;
	endfunction

	function automatic void model_config(logic [2:0] idx, logic [11:0] value);
		case (idx)
		REG_CLIP_LEFT:   clip_l = $signed(value);
		REG_CLIP_RIGHT:  clip_r = $signed(value);
		REG_TRACKING:    track = $signed(value[4:0]);
		REG_FONT_HEIGHT: font_h = value[5:0];
		REG_DRAW_VALUE:  draw_val = value[0];
		default: ;
		endcase
	endfunction

	function automatic void model_word(word_t w);
		int wd, bpr, h, x0, px, addr;
		logic [15:0] mask;
		span_t s;
		case (w.cmd)
		CMD_LOAD_GLYPH: begin
			gl_width[w.code] = (w.width > MAX_GLYPH_WIDTH) ? MAX_GLYPH_WIDTH : w.width;
			gl_offset[w.code] = w.addr;
			gl_known[w.code] = 1'b1;
		end
		CMD_LOAD_BYTE: begin
			font_rom[w.addr] = w.data;
			rom_known[w.addr] = 1'b1;
		end
		CMD_DRAW: begin
			if (w.first) begin
				pen_x = w.sx;
				origin_x = pen_x;
				pen_y = w.sy;
				stopped = 1'b0;
			end
			if (stopped)
				return;
			if (pen_x >= clip_r || pen_x >= DISPLAY_WIDTH) begin
				stopped = 1'b1;
				return;
			end
			wd = gl_width[w.code];
			bpr = (wd + 7) / 8;
			h = font_rows();
			x0 = pen_x;
			pen_x = x0 + wd + track;
			if (pen_x < PEN_MIN)
				pen_x = PEN_MIN;
			else if (pen_x > PEN_MAX)
				pen_x = PEN_MAX;
			s.span_x = 13'(x0);
			s.value = draw_val;
			s.advance = 13'(pen_x - origin_x);
			if (x0 + wd > clip_l) begin
				for (int row = 0; row < h; row++) begin
					mask = '0;
					for (int col = 0; col < wd; col++) begin
						px = x0 + col;
						addr = (gl_offset[w.code] + row * bpr + col / 8) % BITMAP_BYTES_DEF;
						if (px >= clip_l && px < clip_r && font_rom[addr][7 - col % 8])
							mask[col] = 1'b1;
					end
					s.row_y = 13'(pen_y + row);
					s.mask = mask;
					s.last = (row == h - 1);
					spans_due.push_back(s);
				end
			end else begin
				s.row_y = 13'(pen_y);
				s.mask = '0;
				s.last = 1'b1;
				spans_due.push_back(s);
			end
		end
		default: ;
		endcase
	endfunction

	function automatic word_t random_word();
		word_t w;
		w.cmd = 2'($urandom);
		w.code = 8'($urandom);
		w.first = 1'($urandom);
		w.sx = 12'($urandom);
		w.sy = 12'($urandom);
		w.width = 5'($urandom);
		w.addr = 12'($urandom);
		w.data = 8'($urandom);
		return w;
	endfunction

	function automatic void check_field(string name, logic signed [16:0] want,
			logic signed [16:0] got);
		if (got !== want) begin
			errors++;
			$display("%0t: %s expected %0d, got %0d", $time, name, want, got);
		end
	endfunction

	// checker: compare each accepted span with the oldest expectation
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (spans_due.size() == 0) begin
				errors++;
				$display("%0t: span with none expected: row_y %0d span_x %0d mask %h last %b",
					$time, row_y, span_x, pixel_mask, last);
			end else begin
				due_span = spans_due.pop_front();
				check_field("row_y", due_span.row_y, row_y);
				check_field("span_x", due_span.span_x, span_x);
				check_field("pixel_mask", due_span.mask, pixel_mask);
				check_field("pixel_value", due_span.value, pixel_value);
				check_field("text_advance", due_span.advance, text_advance);
				check_field("last", due_span.last, last);
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles == STALL_LIMIT) begin
			$display("end of test: mismatches");
			$finish;
		end
	end

	// receiver: long hold when asked, always ready when calm, random stall bursts otherwise
	initial begin
		int burst;
		burst = 0;
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_left > 0) begin
				out_ready <= 1'b0;
				hold_left--;
			end else if (calm) begin
				out_ready <= 1'b1;
			end else if (burst > 0) begin
				burst--;
			end else if ($urandom_range(0, 3) == 0) begin
				out_ready <= 1'b0;
				burst = $urandom_range(0, 5);
			end else begin
				out_ready <= 1'b1;
				burst = $urandom_range(0, 15);
			end
		end
	end

	task automatic send_word(word_t w);
		if (!calm && $urandom_range(0, 4) == 0) begin
			@(negedge clk);
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(negedge clk);
		end else begin
			@(negedge clk);
		end
		in_valid <= 1'b1;
		command <= w.cmd;
		char_code <= w.code;
		first_of_text <= w.first;
		start_x <= w.sx;
		start_y <= w.sy;
		glyph_width <= w.width;
		bitmap_address <= w.addr;
		bitmap_byte <= w.data;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		model_word(w);
	endtask

	task automatic wait_drained();
		@(negedge clk);
		in_valid <= 1'b0;
		while (spans_due.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(logic [2:0] idx, logic [11:0] value);
		@(negedge clk);
		in_valid <= 1'b0;
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		model_config(idx, value);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic load_glyph(logic [7:0] code, logic [4:0] width, logic [11:0] offset);
		word_t w;
		w = random_word();
		w.cmd = CMD_LOAD_GLYPH;
		w.code = code;
		w.width = width;
		w.addr = offset;
		send_word(w);
	endtask

	task automatic load_byte(logic [11:0] addr, logic [7:0] data);
		word_t w;
		w = random_word();
		w.cmd = CMD_LOAD_BYTE;
		w.addr = addr;
		w.data = data;
		send_word(w);
	endtask

	task automatic send_ignored();
		word_t w;
		w = random_word();
		w.cmd = CMD_UNUSED;
		send_word(w);
	endtask

	// load the entry and every byte the glyph can read at the present height, where not yet loaded
	task automatic prime_glyph(logic [7:0] code);
		int h, bpr, addr;
		if (!gl_known[code])
			load_glyph(code, 5'($urandom_range(0, 20)), 12'($urandom));
		h = font_rows();
		bpr = (gl_width[code] + 7) / 8;
		for (int row = 0; row < h; row++)
			for (int c = 0; c < bpr; c++) begin
				addr = (gl_offset[code] + row * bpr + c) % BITMAP_BYTES_DEF;
				if (!rom_known[addr])
					load_byte(12'(addr), 8'($urandom));
			end
	endtask

	task automatic draw_glyph(logic [7:0] code, logic first, logic signed [11:0] sx,
			logic signed [11:0] sy);
		word_t w;
		prime_glyph(code);
		w = random_word();
		w.cmd = CMD_DRAW;
		w.code = code;
		w.first = first;
		w.sx = sx;
		w.sy = sy;
		send_word(w);
	endtask

	task automatic test_directed();
		write_reg(REG_FONT_HEIGHT, 12'd2);
		load_glyph(8'h41, 5'd16, 12'd4094);
		load_byte(12'd4094, 8'hFF);
		load_byte(12'd4095, 8'h80);
		load_byte(12'd0, 8'h01);
		load_byte(12'd1, 8'h00);
		load_glyph(8'hFF, 5'd31, 12'd300);
		load_byte(12'd300, 8'hAA);
		load_byte(12'd301, 8'h55);
		load_byte(12'd302, 8'hF0);
		load_byte(12'd303, 8'h0F);
		load_glyph(8'h00, 5'd0, 12'hFFF);
		draw_glyph(8'h41, 1'b1, 12'sd0, 12'h800);
		draw_glyph(8'hFF, 1'b0, 12'sd0, 12'sd0);
		draw_glyph(8'h00, 1'b0, 12'sd0, 12'sd0);
		draw_glyph(8'h41, 1'b1, 12'h7FF, 12'sd3);
		draw_glyph(8'h00, 1'b0, 12'sd0, 12'sd0);
		draw_glyph(8'h41, 1'b1, 12'h800, 12'h7FF);
		send_ignored();
		draw_glyph(8'h41, 1'b1, 12'sd120, 12'sd5);
		draw_glyph(8'hFF, 1'b0, 12'sd0, 12'sd0);
		wait_drained();
		write_reg(REG_CLIP_LEFT, 12'd10);
		write_reg(REG_CLIP_RIGHT, 12'd20);
		draw_glyph(8'h41, 1'b1, 12'sd4, 12'sd0);
		draw_glyph(8'hFF, 1'b0, 12'sd0, 12'sd0);
		wait_drained();
		write_reg(REG_CLIP_RIGHT, 12'd5);
		draw_glyph(8'h41, 1'b1, 12'sd0, 12'sd9);
		wait_drained();
	endtask

	task automatic test_registers();
		load_glyph(8'h01, 5'd1, 12'd2000);
		write_reg(REG_CLIP_LEFT, 12'h800);
		write_reg(REG_CLIP_RIGHT, 12'h7FF);
		write_reg(REG_FONT_HEIGHT, 12'hFC0);
		write_reg(REG_TRACKING, 12'h018);
		write_reg(REG_DRAW_VALUE, 12'hFFE);
		draw_glyph(8'h01, 1'b1, 12'sd2, 12'sd0);
		draw_glyph(8'h00, 1'b0, 12'sd0, 12'sd0);
		wait_drained();
		write_reg(REG_FONT_HEIGHT, 12'd63);
		write_reg(REG_TRACKING, 12'd15);
		write_reg(REG_DRAW_VALUE, 12'd1);
		draw_glyph(8'h00, 1'b1, 12'h7F0, 12'h7F0);
		draw_glyph(8'h01, 1'b1, 12'sd100, 12'h800);
		draw_glyph(8'h01, 1'b0, 12'sd0, 12'sd0);
		wait_drained();
		write_reg(REG_FONT_HEIGHT, 12'd32);
		write_reg(REG_CLIP_LEFT, 12'h7FF);
		write_reg(REG_CLIP_RIGHT, 12'h800);
		draw_glyph(8'h00, 1'b1, 12'sd0, 12'sd0);
		draw_glyph(8'h01, 1'b0, 12'sd0, 12'sd0);
		wait_drained();
		write_reg(3'(REG_DRAW_VALUE + $urandom_range(1, 3)), 12'($urandom));
		draw_glyph(8'h00, 1'b1, 12'h800, 12'sd0);
		wait_drained();
	endtask

	task automatic test_backpressure();
		write_reg(REG_CLIP_LEFT, 12'd0);
		write_reg(REG_CLIP_RIGHT, 12'd128);
		write_reg(REG_TRACKING, 12'd0);
		write_reg(REG_FONT_HEIGHT, 12'd8);
		write_reg(REG_DRAW_VALUE, 12'd1);
		foreach (pool[i]) prime_glyph(pool[i]);
		hold_left = 150;
		for (int i = 0; i < 12; i++)
			draw_glyph(pool[$urandom_range(0, 7)], i == 0, 12'sd0, 12'sd40);
		wait_drained();
	endtask

	// narrow glyphs with negative tracking walk the pen left of the start column
	task automatic test_negative_advance();
		write_reg(REG_CLIP_LEFT, 12'h800);
		write_reg(REG_CLIP_RIGHT, 12'h7FF);
		write_reg(REG_TRACKING, 12'h018);
		load_glyph(8'h00, 5'd0, 12'd0);
		for (int i = 0; i < 20; i++)
			draw_glyph(8'h00, i == 0, 12'h800, 12'($urandom));
		wait_drained();
	endtask

	task automatic random_config();
		int h;
		case ($urandom_range(0, 5))
		0: write_reg(REG_CLIP_LEFT, 12'h800);
		1: write_reg(REG_CLIP_LEFT, 12'($urandom));
		default: write_reg(REG_CLIP_LEFT, 12'($urandom_range(0, 60) - 20));
		endcase
		case ($urandom_range(0, 5))
		0: write_reg(REG_CLIP_RIGHT, 12'h7FF);
		1: write_reg(REG_CLIP_RIGHT, 12'($urandom));
		2: write_reg(REG_CLIP_RIGHT, 12'd128);
		default: write_reg(REG_CLIP_RIGHT, 12'($urandom_range(20, 140)));
		endcase
		write_reg(REG_TRACKING, {7'($urandom), 5'($urandom_range(0, 23) - 8)});
		h = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 63) : $urandom_range(1, 8);
		write_reg(REG_FONT_HEIGHT, {6'($urandom), 6'(h)});
		write_reg(REG_DRAW_VALUE, 12'($urandom));
	endtask

	task automatic test_random_text();
		int draws, run;
		logic [7:0] code;
		logic signed [11:0] sx;
		draws = 0;
		while (draws < 50) begin
			wait_drained();
			calm = (draws >= 38);
			random_config();
			repeat ($urandom_range(2, 5)) begin
				sx = ($urandom_range(0, 7) == 0) ? 12'($urandom) : 12'($urandom_range(0, 170) - 40);
				run = $urandom_range(1, 12);
				for (int i = 0; i < run; i++) begin
					case ($urandom_range(0, 19))
					0: load_glyph(pool[$urandom_range(0, 7)], 5'($urandom_range(0, 20)),
						12'($urandom));
					1, 2: load_byte(12'($urandom), 8'($urandom));
					3: send_ignored();
					default: ;
					endcase
					code = ($urandom_range(0, 9) == 0) ? 8'($urandom) : pool[$urandom_range(0, 7)];
					draw_glyph(code, i == 0 || $urandom_range(0, 15) == 0, sx, 12'($urandom));
					draws++;
				end
			end
		end
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		command = CMD_LOAD_GLYPH;
		char_code = '0;
		first_of_text = 1'b0;
		start_x = '0;
		start_y = '0;
		glyph_width = '0;
		bitmap_address = '0;
		bitmap_byte = '0;
		cfg_valid = 1'b0;
		cfg_index = REG_CLIP_LEFT;
		cfg_data = '0;
		model_reset();
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		test_directed();
		test_registers();
		test_backpressure();
		test_negative_advance();
		test_random_text();
		wait_drained();
		if (spans_due.size() != 0) begin
			errors++;
			$display("%0t: %0d spans never arrived", $time, spans_due.size());
		end
		if (errors == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule

>>> sim.f
src/pgb_pkg.sv
src/pgb_addr_mod.sv
src/pgb_glyph_store.sv
src/pgb_bitmap_store.sv
src/proportional_glyph_row_blitter_top.sv
tb/tb.sv
